// ===== sv/mde_pkg.sv =====
// Shared types, constants and tables of the multiband downward expander.
package mde_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int SLOTS       = 10;
    localparam int PART_W      = 37;
    localparam int SUM_W       = 41;

    // Request codes
    localparam logic [1:0] REQ_SAMPLE   = 2'd0;
    localparam logic [1:0] REQ_COEF     = 2'd1;
    localparam logic [1:0] REQ_CLEAR    = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    // Coefficient slots
    localparam logic [3:0] SLOT_B0      = 4'd0;
    localparam logic [3:0] SLOT_B1      = 4'd1;
    localparam logic [3:0] SLOT_B2      = 4'd2;
    localparam logic [3:0] SLOT_A1      = 4'd3;
    localparam logic [3:0] SLOT_A2      = 4'd4;
    localparam logic [3:0] SLOT_ATTACK  = 4'd5;
    localparam logic [3:0] SLOT_RELEASE = 4'd6;
    localparam logic [3:0] SLOT_THRESH  = 4'd7;
    localparam logic [3:0] SLOT_SLOPE   = 4'd8;
    localparam logic [3:0] SLOT_GAIN    = 4'd9;

    // Configuration register index
    localparam logic REG_ACTIVE_BANDS = 1'b0;
    localparam logic [3:0] ACTIVE_BANDS_RESET = 4'd4;

    // log2 of 1e-10 in Q16, used for a zero envelope
    localparam logic signed [23:0] LOG2_FLOOR = -24'sd2177059;

    localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] OUT_MIN = SUM_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    // Command bundle broadcast from the controller to every cell
    typedef struct packed {
        logic                          start;
        logic                          clear;
        logic                          wr;
        logic [2:0]                    wr_band;
        logic [3:0]                    wr_slot;
        logic signed [COEF_BITS-1:0]   wr_value;
        logic signed [SAMPLE_BITS-1:0] x0;
        logic signed [SAMPLE_BITS-1:0] x1;
        logic signed [SAMPLE_BITS-1:0] x2;
    } t_cell_cmd;

    // 2^(2^-(k+1)) in Q1.30
    function automatic logic [30:0] pow2_tab(input logic [3:0] k);
        logic [30:0] v;
        unique case (k)
            4'd0:    v = 31'd1518500250;
            4'd1:    v = 31'd1276901417;
            4'd2:    v = 31'd1170923762;
            4'd3:    v = 31'd1121280437;
            4'd4:    v = 31'd1097253712;
            4'd5:    v = 31'd1085434105;
            4'd6:    v = 31'd1079572146;
            4'd7:    v = 31'd1076653033;
            4'd8:    v = 31'd1075196443;
            4'd9:    v = 31'd1074468887;
            4'd10:   v = 31'd1074105294;
            4'd11:   v = 31'd1073923543;
            4'd12:   v = 31'd1073832680;
            4'd13:   v = 31'd1073787251;
            4'd14:   v = 31'd1073764537;
            default: v = 31'd1073753181;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/mde_cell.sv =====
// One band cell: biquad, envelope follower, log2/exp2 gain and a link of the sum chain.
module mde_cell #(
    parameter int BAND_IDX = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mde_pkg::t_cell_cmd                   i_cmd,
    input  logic                                 i_en,
    input  logic signed [mde_pkg::SUM_W-1:0]     i_sum,
    output logic signed [mde_pkg::SUM_W-1:0]     o_sum,
    output logic                                 o_busy
);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_BQ   = 13'b0000000000010,
        S_ENV1 = 13'b0000000000100,
        S_ENV2 = 13'b0000000001000,
        S_NORM = 13'b0000000010000,
        S_SQ   = 13'b0000000100000,
        S_LG   = 13'b0000001000000,
        S_EX   = 13'b0000010000000,
        S_PW   = 13'b0000100000000,
        S_PWE  = 13'b0001000000000,
        S_OUT1 = 13'b0010000000000,
        S_OUT2 = 13'b0100000000000,
        S_OUT3 = 13'b1000000000000
    } t_cstate;

    t_cstate                             r_state;
    logic signed [31:0]                  r_coef [mde_pkg::SLOTS];
    logic signed [31:0]                  r_bd1;
    logic signed [31:0]                  r_bd2;
    logic [31:0]                         r_env;
    logic [3:0]                          r_k;
    logic signed [67:0]                  r_prod;
    logic signed [39:0]                  r_acc;
    logic signed [31:0]                  r_y;
    logic [31:0]                         r_m;
    logic [4:0]                          r_p;
    logic [15:0]                         r_frac;
    logic                                r_zero;
    logic [5:0]                          r_ip;
    logic [15:0]                         r_f;
    logic [30:0]                         r_g;
    logic signed [mde_pkg::PART_W-1:0]   r_part;
    logic signed [mde_pkg::SUM_W-1:0]    r_sum;

    logic signed [33:0] w_ma;
    logic signed [33:0] w_mb;
    logic signed [67:0] w_mp;
    logic signed [67:0] w_sh29;
    logic signed [67:0] w_sh30;
    logic signed [67:0] w_sh28;
    logic signed [39:0] w_term;
    logic signed [31:0] w_y;
    logic signed [32:0] w_y33;
    logic [32:0]        w_mag;
    logic signed [33:0] w_d;
    logic signed [31:0] w_rsel;
    logic [29:0]        w_rate;
    logic signed [35:0] w_envs;
    logic [31:0]        w_envn;
    logic [32:0]        w_t;
    logic signed [6:0]  w_poff;
    logic signed [23:0] w_lg;
    logic               w_below;
    logic signed [32:0] w_diff;
    logic signed [23:0] w_dcl;
    logic signed [22:0] w_ex;
    logic signed [22:0] w_ee;
    logic               w_hit;

    // Pick the shared multiplier's operands for the current step
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_BQ: begin
                unique case (r_k)
                    4'd0: begin w_ma = 34'(r_coef[mde_pkg::SLOT_B0]); w_mb = 34'(i_cmd.x0); end
                    4'd1: begin w_ma = 34'(r_coef[mde_pkg::SLOT_B1]); w_mb = 34'(i_cmd.x1); end
                    4'd2: begin w_ma = 34'(r_coef[mde_pkg::SLOT_B2]); w_mb = 34'(i_cmd.x2); end
                    4'd3: begin w_ma = 34'(r_coef[mde_pkg::SLOT_A1]); w_mb = 34'(r_bd1); end
                    4'd4: begin w_ma = 34'(r_coef[mde_pkg::SLOT_A2]); w_mb = 34'(r_bd2); end
                    default: begin w_ma = '0; w_mb = '0; end
                endcase
            end
            S_ENV1: begin
                w_ma = $signed({4'b0, w_rate});
                w_mb = w_d;
            end
            S_SQ: begin
                w_ma = $signed({2'b0, r_m});
                w_mb = $signed({2'b0, r_m});
            end
            S_LG: begin
                w_ma = 34'(r_coef[mde_pkg::SLOT_SLOPE]);
                w_mb = 34'(w_dcl);
            end
            S_PW: begin
                w_ma = $signed({3'b0, r_g});
                w_mb = $signed({3'b0, mde_pkg::pow2_tab(r_k)});
            end
            S_OUT1: begin
                w_ma = 34'(r_y);
                w_mb = $signed({3'b0, r_g});
            end
            S_OUT2: begin
                w_ma = $signed(w_sh30[33:0]);
                w_mb = 34'(r_coef[mde_pkg::SLOT_GAIN]);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mp   = w_ma * w_mb;
    assign w_sh29 = r_prod >>> 29;
    assign w_sh30 = r_prod >>> 30;
    assign w_sh28 = r_prod >>> 28;
    assign w_term = $signed(w_sh29[39:0]);

    // Saturate the biquad sum and form the envelope step
    always_comb begin
        if (r_acc > 40'sd2147483647)
            w_y = 32'sh7FFFFFFF;
        else if (r_acc < -40'sd2147483648)
            w_y = 32'sh80000000;
        else
            w_y = $signed(r_acc[31:0]);
        w_y33  = 33'(w_y);
        w_mag  = w_y33[32] ? $unsigned(33'(-w_y33)) : $unsigned(w_y33);
        w_d    = $signed({1'b0, w_mag}) - $signed({2'b0, r_env});
        w_rsel = (w_mag > {1'b0, r_env}) ? r_coef[mde_pkg::SLOT_ATTACK]
                                         : r_coef[mde_pkg::SLOT_RELEASE];
        if (w_rsel < 32'sd0)
            w_rate = '0;
        else if (w_rsel > 32'sd536870912)
            w_rate = 30'd536870912;
        else
            w_rate = w_rsel[29:0];
    end

    // Apply the envelope step and clamp to 32 bits unsigned
    always_comb begin
        w_envs = $signed({4'b0, r_env}) + $signed(w_sh29[35:0]);
        if (w_envs < 36'sd0)
            w_envn = '0;
        else if (w_envs > 36'sd4294967295)
            w_envn = '1;
        else
            w_envn = w_envs[31:0];
    end

    assign w_t = w_mp[63:31];

    // Assemble log2 of the envelope and the clamped distance below threshold
    always_comb begin
        w_poff  = $signed({2'b0, r_p}) - 7'sd23;
        w_lg    = r_zero ? mde_pkg::LOG2_FLOOR : 24'($signed({w_poff, r_frac}));
        w_below = 33'(w_lg) < 33'(r_coef[mde_pkg::SLOT_THRESH]);
        w_diff  = 33'(w_lg) - 33'(r_coef[mde_pkg::SLOT_THRESH]);
        if (w_diff < -33'sd4194304)
            w_dcl = -24'sd4194304;
        else if (w_diff > 33'sd0)
            w_dcl = '0;
        else
            w_dcl = $signed(w_diff[23:0]);
    end

    // Clamp the gain exponent to [-32, 0] and bias it positive
    always_comb begin
        if (w_sh29 < -68'sd2097152)
            w_ex = -23'sd2097152;
        else if (w_sh29 > 68'sd0)
            w_ex = '0;
        else
            w_ex = $signed(w_sh29[22:0]);
        w_ee  = w_ex + 23'sd2097152;
        w_hit = r_f[4'd15 - r_k];
    end

    // Sequence one band's work and hold its coefficients and histories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bd1   <= '0;
            r_bd2   <= '0;
            r_env   <= '0;
            for (int i = 0; i < mde_pkg::SLOTS; i++)
                r_coef[i] <= '0;
        end else begin
            if (i_cmd.wr && int'(i_cmd.wr_band) == BAND_IDX
                    && i_cmd.wr_slot < 4'(mde_pkg::SLOTS)) begin
                r_coef[i_cmd.wr_slot] <= i_cmd.wr_value;
            end
            if (i_cmd.clear) begin
                r_bd1 <= '0;
                r_bd2 <= '0;
                r_env <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.start && i_en) begin
                        r_acc   <= '0;
                        r_k     <= '0;
                        r_state <= S_BQ;
                    end
                end
                S_BQ: begin
                    r_prod <= w_mp;
                    if (r_k != 4'd0) begin
                        if (r_k > 4'd3)
                            r_acc <= r_acc - w_term;
                        else
                            r_acc <= r_acc + w_term;
                    end
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd5)
                        r_state <= S_ENV1;
                end
                S_ENV1: begin
                    r_prod  <= w_mp;
                    r_y     <= w_y;
                    r_bd2   <= r_bd1;
                    r_bd1   <= w_y;
                    r_state <= S_ENV2;
                end
                S_ENV2: begin
                    r_env <= w_envn;
                    r_m   <= w_envn;
                    r_p   <= 5'd31;
                    if (w_envn == '0) begin
                        r_zero  <= 1'b1;
                        r_state <= S_LG;
                    end else begin
                        r_zero  <= 1'b0;
                        r_state <= S_NORM;
                    end
                end
                // Shift left one place a cycle until the leading one is at the top
                S_NORM: begin
                    if (r_m[31]) begin
                        r_k     <= '0;
                        r_frac  <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_m <= {r_m[30:0], 1'b0};
                        r_p <= r_p - 5'd1;
                    end
                end
                // One fraction bit per squaring step
                S_SQ: begin
                    r_frac <= {r_frac[14:0], w_t[32]};
                    r_m    <= w_t[32] ? w_t[32:1] : w_t[31:0];
                    r_k    <= r_k + 4'd1;
                    if (r_k == 4'd15)
                        r_state <= S_LG;
                end
                S_LG: begin
                    r_prod <= w_mp;
                    r_g    <= 31'd1073741824;
                    if (w_below)
                        r_state <= S_EX;
                    else
                        r_state <= S_OUT1;
                end
                S_EX: begin
                    r_ip    <= w_ee[21:16];
                    r_f     <= w_ee[15:0];
                    r_k     <= '0;
                    r_state <= S_PW;
                end
                // Multiply in one table entry per set fraction bit
                S_PW: begin
                    if (w_hit)
                        r_g <= w_mp[60:30];
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd15)
                        r_state <= S_PWE;
                end
                S_PWE: begin
                    r_g     <= r_g >> (6'd32 - r_ip);
                    r_state <= S_OUT1;
                end
                S_OUT1: begin
                    r_prod  <= w_mp;
                    r_state <= S_OUT2;
                end
                S_OUT2: begin
                    r_prod  <= w_mp;
                    r_state <= S_OUT3;
                end
                S_OUT3: begin
                    r_part  <= $signed(w_sh28[mde_pkg::PART_W-1:0]);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Add this band's part to the running sum and pass it on
    always_ff @(posedge i_clk) begin
        r_sum <= i_sum + (i_en ? mde_pkg::SUM_W'(r_part) : mde_pkg::SUM_W'(0));
    end

    assign o_sum  = r_sum;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== sv/multiband_downward_expander_unit.sv =====
// Top level of the multiband downward expander: controller, register port and cell chain.
//
// A row of MAX_BANDS band cells works on each audio sample in parallel, each cell running
// its own sequencer around one shared multiplier: five biquad products, an envelope step,
// a leading-one search, sixteen squaring steps for log2, sixteen table steps for 2^x and
// two output products, with fewer steps when the envelope is zero or above threshold. The
// band parts then ripple down a registered sum chain to the result; the log2 and exp2
// iterations in the cells take up most of a sample's time. Coefficient writes and clears
// give no result. One item is worked on at a time; a finished result waits in the output
// register while the next item is taken.
module multiband_downward_expander_unit #(
    parameter int MAX_BANDS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_req_type,
    input  logic signed [mde_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic [2:0]                           i_coef_band,
    input  logic [3:0]                           i_coef_slot,
    input  logic signed [31:0]                   i_coef_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [mde_pkg::SAMPLE_BITS-1:0] o_sample_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int CNT_W = $clog2(MAX_BANDS + 1);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_RUN  = 3'b010,
        T_SUM  = 3'b100
    } t_tstate;

    t_tstate                                r_state;
    logic [CNT_W-1:0]                       r_cnt;
    logic [3:0]                             r_active_bands;
    logic signed [mde_pkg::SAMPLE_BITS-1:0] r_x0;
    logic signed [mde_pkg::SAMPLE_BITS-1:0] r_x1;
    logic signed [mde_pkg::SAMPLE_BITS-1:0] r_x2;
    logic                                   r_out_valid;
    logic signed [mde_pkg::SAMPLE_BITS-1:0] r_out;

    logic                                   w_in_fire;
    logic                                   w_out_free;
    logic                                   w_deliver;
    mde_pkg::t_cell_cmd                     w_cmd;
    logic [MAX_BANDS-1:0]                   w_en;
    logic [MAX_BANDS-1:0]                   w_busy;
    logic signed [mde_pkg::SUM_W-1:0]       w_sum [MAX_BANDS+1];
    logic signed [mde_pkg::SUM_W-1:0]       w_last;
    logic signed [mde_pkg::SAMPLE_BITS-1:0] w_sat;

    assign o_in_ready = (r_state == T_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_deliver  = (r_state == T_SUM) && (r_cnt >= CNT_W'(MAX_BANDS - 1)) && w_out_free;

    // Register port: write and read back the band count
    assign pready = 1'b1;
    assign prdata = (paddr[2] == mde_pkg::REG_ACTIVE_BANDS) ? {28'b0, r_active_bands} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_bands <= mde_pkg::ACTIVE_BANDS_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == mde_pkg::REG_ACTIVE_BANDS) begin
            r_active_bands <= pwdata[3:0];
        end
    end

    // Enable the first active_bands cells; zero acts as one
    always_comb begin
        for (int i = 0; i < MAX_BANDS; i++)
            w_en[i] = (r_active_bands == 4'd0) ? (i == 0) : (int'(r_active_bands) > i);
    end

    // Broadcast the accepted beat to the cells
    always_comb begin
        w_cmd.start    = w_in_fire && (i_req_type == mde_pkg::REQ_SAMPLE);
        w_cmd.clear    = w_in_fire && (i_req_type == mde_pkg::REQ_CLEAR);
        w_cmd.wr       = w_in_fire && (i_req_type == mde_pkg::REQ_COEF);
        w_cmd.wr_band  = i_coef_band;
        w_cmd.wr_slot  = i_coef_slot;
        w_cmd.wr_value = i_coef_value;
        w_cmd.x0       = i_sample_in;
        w_cmd.x1       = r_x1;
        w_cmd.x2       = r_x2;
        // cells read x0 only after the start edge, from the held sample
        if (r_state != T_IDLE)
            w_cmd.x0 = r_x0;
    end

    // Chain of band cells
    assign w_sum[0] = '0;

    for (genvar g = 0; g < MAX_BANDS; g++) begin : g_cell
        mde_cell #(
            .BAND_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_en    (w_en[g]),
            .i_sum   (w_sum[g]),
            .o_sum   (w_sum[g+1]),
            .o_busy  (w_busy[g])
        );
    end

    // Saturate the band sum to the sample width
    assign w_last = w_sum[MAX_BANDS];
    always_comb begin
        if (w_last > mde_pkg::OUT_MAX)
            w_sat = mde_pkg::SAMPLE_BITS'(mde_pkg::OUT_MAX);
        else if (w_last < mde_pkg::OUT_MIN)
            w_sat = mde_pkg::SAMPLE_BITS'(mde_pkg::OUT_MIN);
        else
            w_sat = w_last[mde_pkg::SAMPLE_BITS-1:0];
    end

    // Controller: start the cells, wait for them, let the sum settle, deliver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_cnt       <= '0;
            r_x1        <= '0;
            r_x2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_deliver)
                r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready)
                r_out_valid <= 1'b0;
            unique case (r_state)
                T_IDLE: begin
                    if (w_cmd.start) begin
                        r_x0    <= i_sample_in;
                        r_state <= T_RUN;
                    end
                    if (w_cmd.clear) begin
                        r_x1 <= '0;
                        r_x2 <= '0;
                    end
                end
                T_RUN: begin
                    if (!(|w_busy)) begin
                        r_x2    <= r_x1;
                        r_x1    <= r_x0;
                        r_cnt   <= '0;
                        r_state <= T_SUM;
                    end
                end
                T_SUM: begin
                    if (r_cnt >= CNT_W'(MAX_BANDS - 1)) begin
                        if (w_deliver) begin
                            r_out   <= w_sat;
                            r_state <= T_IDLE;
                        end
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    // No cell may still be working while the sum settles
    a_sum_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_SUM) |-> !(|w_busy))
        else $error("cell busy during sum");

    // A sample beat starts the run
    a_start_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_req_type == mde_pkg::REQ_SAMPLE) |=> (r_state == T_RUN))
        else $error("sample beat did not start a run");

    // A result appears only out of the sum phase
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == T_SUM))
        else $error("result raised outside the sum phase");

endmodule
